[hdl/cdm_pkg.sv]
// Shared types, constants and arithmetic helpers for the clock display mux.
package cdm_pkg;

    localparam int unsigned HourW   = 5;
    localparam int unsigned MinuteW = 6;
    localparam int unsigned DigitW  = 4;
    localparam int unsigned DriveW  = 16;
    localparam int unsigned StepW   = 2;
    localparam int unsigned IndexW  = 2;

    localparam logic [StepW-1:0]  StepLimit  = 2'd2;
    localparam logic [DigitW-1:0] ErrorDigit = 4'd9;

    // Event codes carried in the input tuser
    typedef enum logic [1:0] {
        EV_TICK   = 2'd0,
        EV_BUTTON = 2'd1,
        EV_KNOB   = 2'd2,
        EV_RTC    = 2'd3
    } t_event;

    // Result kind carried in the output tuser
    typedef enum logic {
        KIND_DRIVE = 1'b0,
        KIND_SAVE  = 1'b1
    } t_kind;

    typedef enum logic [3:0] {
        ST_VIEW    = 4'b0001,
        ST_SET_HR  = 4'b0010,
        ST_SET_MIN = 4'b0100,
        ST_ERROR   = 4'b1000
    } t_mode_state;

    typedef struct packed {
        logic               valid;
        t_kind              kind;
        logic [DriveW-1:0]  drive_word;
        logic [HourW-1:0]   save_hour;
        logic [MinuteW-1:0] save_minute;
    } t_result;

    // Step an hour by one with wrap at 24; value may be out of range (up to 31)
    function automatic logic [HourW-1:0] wrap_hour(input logic [HourW-1:0] v,
                                                   input logic up);
        logic [HourW:0] t;
        begin
            if (up) begin
                t = {1'b0, v} + 6'd1;
                if (t >= 6'd24) t = t - 6'd24;
            end else begin
                t = {1'b0, v} + 6'd23;
                if (t >= 6'd48) t = t - 6'd48;
                else if (t >= 6'd24) t = t - 6'd24;
            end
            return t[HourW-1:0];
        end
    endfunction

    // Step a minute by one with wrap at 60; value may be out of range (up to 63)
    function automatic logic [MinuteW-1:0] wrap_minute(input logic [MinuteW-1:0] v,
                                                       input logic up);
        logic [MinuteW:0] t;
        begin
            if (up) begin
                t = {1'b0, v} + 7'd1;
                if (t >= 7'd60) t = t - 7'd60;
            end else begin
                t = {1'b0, v} + 7'd59;
                if (t >= 7'd120) t = t - 7'd120;
                else if (t >= 7'd60) t = t - 7'd60;
            end
            return t[MinuteW-1:0];
        end
    endfunction

    function automatic logic [DigitW-1:0] tens_of(input logic [MinuteW-1:0] v);
        logic [DigitW-1:0] d;
        begin
            if      (v >= 6'd60) d = 4'd6;
            else if (v >= 6'd50) d = 4'd5;
            else if (v >= 6'd40) d = 4'd4;
            else if (v >= 6'd30) d = 4'd3;
            else if (v >= 6'd20) d = 4'd2;
            else if (v >= 6'd10) d = 4'd1;
            else                 d = 4'd0;
            return d;
        end
    endfunction

    function automatic logic [DigitW-1:0] ones_of(input logic [MinuteW-1:0] v);
        logic [DigitW-1:0] t;
        logic [MinuteW:0]  r;
        begin
            t = tens_of(v);
            r = {1'b0, v} - ({3'd0, t} * 7'd10);
            return r[DigitW-1:0];
        end
    endfunction

    // Board wiring: b0=D0, b1=D3, b2=D1, b3=D2
    function automatic logic [DigitW-1:0] permute_bcd(input logic [DigitW-1:0] d);
        return {d[2], d[1], d[3], d[0]};
    endfunction

endpackage

[hdl/cdm_fmt.sv]
// Drive word formatter: digit select, BCD split, permutation and anode scan.
module cdm_fmt (
    input  cdm_pkg::t_mode_state               i_state,
    input  logic [cdm_pkg::IndexW-1:0]          i_index,
    input  logic [cdm_pkg::HourW-1:0]           i_hour,
    input  logic [cdm_pkg::MinuteW-1:0]         i_minute,
    output logic [cdm_pkg::DriveW-1:0]          o_drive_word
);

    logic [cdm_pkg::DigitW-1:0] w_digit;
    logic [3:0]                 w_anode;
    logic [1:0]                 w_set_bits;

    always_comb begin
        case (i_index)
            2'd0:    w_digit = cdm_pkg::tens_of({1'b0, i_hour});
            2'd1:    w_digit = cdm_pkg::ones_of({1'b0, i_hour});
            2'd2:    w_digit = cdm_pkg::tens_of(i_minute);
            default: w_digit = cdm_pkg::ones_of(i_minute);
        endcase
        if (i_state == cdm_pkg::ST_ERROR) w_digit = cdm_pkg::ErrorDigit;
    end

    always_comb begin
        case (i_state)
            cdm_pkg::ST_SET_HR:  w_set_bits = 2'b01;
            cdm_pkg::ST_SET_MIN: w_set_bits = 2'b10;
            default:             w_set_bits = 2'b00;
        endcase
    end

    assign w_anode      = 4'b0001 << i_index;
    assign o_drive_word = {4'd0, w_anode, 2'd0, w_set_bits, cdm_pkg::permute_bcd(w_digit)};

endmodule

[hdl/cdm_core.sv]
// Mode machine, time counters and knob step counters; forms at most one result per request.
module cdm_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  cdm_pkg::t_event             i_event,
    input  logic                        i_rot_direction,
    input  logic                        i_rtc_ok,
    input  logic [cdm_pkg::HourW-1:0]   i_rtc_hour,
    input  logic [cdm_pkg::MinuteW-1:0] i_rtc_minute,
    output cdm_pkg::t_result            o_result
);

    cdm_pkg::t_mode_state          r_state, n_state;
    logic [cdm_pkg::HourW-1:0]     r_hour, n_hour;
    logic [cdm_pkg::MinuteW-1:0]   r_minute, n_minute;
    logic [cdm_pkg::IndexW-1:0]    r_index, n_index;
    logic [cdm_pkg::StepW-1:0]     r_up, n_up;
    logic [cdm_pkg::StepW-1:0]     r_down, n_down;

    logic                          w_in_set;
    logic                          w_do_up;
    logic                          w_do_down;
    logic [cdm_pkg::HourW-1:0]     w_tick_hour;
    logic [cdm_pkg::MinuteW-1:0]   w_tick_minute;
    logic [cdm_pkg::DriveW-1:0]    w_drive_word;

    // Pending knob step applied on a tick, up first
    assign w_in_set  = (r_state == cdm_pkg::ST_SET_HR) || (r_state == cdm_pkg::ST_SET_MIN);
    assign w_do_up   = w_in_set && (r_up >= cdm_pkg::StepLimit);
    assign w_do_down = w_in_set && !w_do_up && (r_down >= cdm_pkg::StepLimit);

    always_comb begin
        w_tick_hour   = r_hour;
        w_tick_minute = r_minute;
        if (w_do_up || w_do_down) begin
            if (r_state == cdm_pkg::ST_SET_HR)
                w_tick_hour = cdm_pkg::wrap_hour(r_hour, w_do_up);
            else
                w_tick_minute = cdm_pkg::wrap_minute(r_minute, w_do_up);
        end
    end

    cdm_fmt u_fmt (
        .i_state      (r_state),
        .i_index      (r_index),
        .i_hour       (w_tick_hour),
        .i_minute     (w_tick_minute),
        .o_drive_word (w_drive_word)
    );

    always_comb begin
        n_state  = r_state;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_index  = r_index;
        n_up     = r_up;
        n_down   = r_down;
        o_result = '{valid: 1'b0, kind: cdm_pkg::KIND_DRIVE, drive_word: '0,
                     save_hour: '0, save_minute: '0};
        case (i_event)
            cdm_pkg::EV_TICK: begin
                n_hour   = w_tick_hour;
                n_minute = w_tick_minute;
                if (w_do_up)   n_up   = '0;
                if (w_do_down) n_down = '0;
                n_index  = r_index + 2'd1;
                o_result.valid      = 1'b1;
                o_result.drive_word = w_drive_word;
            end
            cdm_pkg::EV_BUTTON: begin
                case (r_state)
                    cdm_pkg::ST_VIEW:   n_state = cdm_pkg::ST_SET_HR;
                    cdm_pkg::ST_SET_HR: n_state = cdm_pkg::ST_SET_MIN;
                    cdm_pkg::ST_SET_MIN: begin
                        n_state              = cdm_pkg::ST_VIEW;
                        o_result.valid       = 1'b1;
                        o_result.kind        = cdm_pkg::KIND_SAVE;
                        o_result.save_hour   = r_hour;
                        o_result.save_minute = r_minute;
                    end
                    default:            n_state = r_state;
                endcase
            end
            cdm_pkg::EV_KNOB: begin
                // Saturate at the step limit, clear the opposite direction
                if (i_rot_direction) begin
                    if (r_up < cdm_pkg::StepLimit) n_up = r_up + 2'd1;
                    n_down = '0;
                end else begin
                    if (r_down < cdm_pkg::StepLimit) n_down = r_down + 2'd1;
                    n_up = '0;
                end
            end
            default: begin
                if (!i_rtc_ok) begin
                    n_state = cdm_pkg::ST_ERROR;
                end else if (r_state == cdm_pkg::ST_VIEW) begin
                    n_hour   = i_rtc_hour;
                    n_minute = i_rtc_minute;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cdm_pkg::ST_VIEW;
            r_hour   <= '0;
            r_minute <= '0;
            r_index  <= '0;
            r_up     <= '0;
            r_down   <= '0;
        end else if (i_en) begin
            r_state  <= n_state;
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_index  <= n_index;
            r_up     <= n_up;
            r_down   <= n_down;
        end
    end

endmodule

[hdl/clock_display_mux_and_time_set_unit.sv]
// Top level of the clock display mux: input register, step core and result register.
//
//  channel  | dir | tuser        | tdata (low bit first)
//  s_axis   | in  | [1:0] event  | [0] rot_direction, [1] rtc_ok, [6:2] rtc_hour,
//           |     |              | [12:7] rtc_minute, [15:13] zero
//  m_axis   | out | [0] kind     | [15:0] drive_word, [20:16] save_hour,
//           |     |              | [26:21] save_minute, [31:27] zero
//
// One request per cycle while m_axis does not stall; a request passes the input register, then the result register.
// The step core updates its state in the cycle a request leaves the input register.
// Button presses outside set-minute, knob edges and RTC reports produce no result.
// A stalled m_axis holds the result; the input register still takes one more request.
// Reset (i_rst_n low, synchronous) returns to view with time 00:00 and digit 0.
module clock_display_mux_and_time_set_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // rot_direction, rtc_ok, rtc_hour, rtc_minute
    input  logic [1:0]  s_axis_tuser,   // event
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // drive_word, save_hour, save_minute
    output logic        m_axis_tuser    // kind
);

    logic                          r_in_valid;
    cdm_pkg::t_event               r_in_event;
    logic                          r_in_dir;
    logic                          r_in_ok;
    logic [cdm_pkg::HourW-1:0]     r_in_hour;
    logic [cdm_pkg::MinuteW-1:0]   r_in_minute;

    logic                          r_out_valid;
    cdm_pkg::t_result              r_out;

    logic                          w_out_free;
    logic                          w_step;
    cdm_pkg::t_result              w_result;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_event  <= cdm_pkg::t_event'(s_axis_tuser);
            r_in_dir    <= s_axis_tdata[0];
            r_in_ok     <= s_axis_tdata[1];
            r_in_hour   <= s_axis_tdata[6:2];
            r_in_minute <= s_axis_tdata[12:7];
        end
    end

    cdm_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_step),
        .i_event         (r_in_event),
        .i_rot_direction (r_in_dir),
        .i_rtc_ok        (r_in_ok),
        .i_rtc_hour      (r_in_hour),
        .i_rtc_minute    (r_in_minute),
        .o_result        (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_step && w_result.valid;
        end
    end

    // Hold the payload while the result waits downstream
    always_ff @(posedge i_clk) begin
        if (w_step && w_result.valid) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {5'd0, r_out.save_minute, r_out.save_hour, r_out.drive_word};

endmodule
